// File: design/paletted_texel_fetch_defines.svh
// ----------------------------------------------------------------------------
// paletted_texel_fetch_defines
// assertion macros used by the paletted texel fetch controller
// ----------------------------------------------------------------------------
`ifndef PALETTED_TEXEL_FETCH_DEFINES_SVH
`define PALETTED_TEXEL_FETCH_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PTF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ptf_pkg.sv
// ----------------------------------------------------------------------------
// ptf_pkg
// shared types and constants of the paletted texel fetch block
// ----------------------------------------------------------------------------
package ptf_pkg;

	// command codes carried in s_tuser
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_DECODE = 2'd2;

	// texture formats from page word bits 8:7, anything else is direct 16-bit
	localparam logic [1:0] FMT_4BIT = 2'd0;
	localparam logic [1:0] FMT_8BIT = 2'd1;

	// beat widths
	localparam int CMD_W     = 2;
	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 48;

	// coordinate width: holds every computed column or row and the largest store edge
	localparam int COORD_W = 13;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	// controller to datapath
	typedef struct packed {
		logic clear_wr;   // write zero at the sweep address
		logic first_acc;  // input beat accepted: first store access
		logic second_rd;  // palette entry read
		logic out_load;   // load the output register
	} ptf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last; // sweep is at the last address
		logic in_result;  // offered beat is a read or a decode
		logic paletted;   // held decode needs a palette read
	} ptf_sts_t;

endpackage

// File: design/ptf_datapath.sv
// ----------------------------------------------------------------------------
// ptf_datapath
// video word store, address generation, index extraction and color expansion
// ----------------------------------------------------------------------------
module ptf_datapath import ptf_pkg::*; #(
	parameter int STORE_WIDTH  = 1024,
	parameter int STORE_HEIGHT = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptf_cmd_t             cmd,
	output ptf_sts_t             sts,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [CMD_W-1:0]     s_tuser,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int CW    = $clog2(STORE_WIDTH);
	localparam int RW    = $clog2(STORE_HEIGHT);
	localparam int AW    = CW + RW;
	localparam int DEPTH = STORE_HEIGHT << CW;
	localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [COORD_W-1:0] W_LIM     = COORD_W'(STORE_WIDTH);
	localparam logic [COORD_W-1:0] H_LIM     = COORD_W'(STORE_HEIGHT);

	function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c,
		input logic [COORD_W-1:0] lim);
		return (c >= lim) ? (lim - COORD_W'(1)) : c;
	endfunction

	// input fields
	logic [9:0]  vram_x;
	logic [8:0]  vram_y;
	logic [15:0] write_data;
	logic [15:0] page_word;
	logic [15:0] palette_word;
	logic [7:0]  tex_u;
	logic [7:0]  tex_v;

	assign vram_x       = s_tdata[9:0];
	assign vram_y       = s_tdata[18:10];
	assign write_data   = s_tdata[34:19];
	assign page_word    = s_tdata[50:35];
	assign palette_word = s_tdata[66:51];
	assign tex_u        = s_tdata[74:67];
	assign tex_v        = s_tdata[82:75];

	logic in_write, in_decode;
	assign in_write      = (s_tuser == CMD_WRITE);
	assign in_decode     = (s_tuser == CMD_DECODE);
	assign sts.in_result = (s_tuser == CMD_READ) || in_decode;

	// first access: texel word or plain read/write location
	logic [1:0]         fmt;
	logic [9:0]         base_x, base_y;
	logic [7:0]         u_off;
	logic [COORD_W-1:0] first_col, first_row, first_col_c, first_row_c;
	logic [AW-1:0]      first_addr;

	assign fmt    = page_word[8:7];
	assign base_x = {page_word[3:0], 6'b0};
	assign base_y = {page_word[11], page_word[4], 8'b0};

	always_comb begin
		case (fmt)
			FMT_4BIT: u_off = {2'b0, tex_u[7:2]};
			FMT_8BIT: u_off = {1'b0, tex_u[7:1]};
			default:  u_off = tex_u;
		endcase
	end

	assign first_col = in_decode ? (COORD_W'(base_x) + COORD_W'(u_off)) : COORD_W'(vram_x);
	assign first_row = in_decode ? (COORD_W'(base_y) + COORD_W'(tex_v)) : COORD_W'(vram_y);
	assign first_col_c = clamp_coord(first_col, W_LIM);
	assign first_row_c = clamp_coord(first_row, H_LIM);
	assign first_addr  = {first_row_c[RW-1:0], first_col_c[CW-1:0]};

	// decode context held across the store accesses
	logic        dec_q, pal4_q, pal8_q;
	logic [1:0]  u_lo_q;
	logic [15:0] pal_word_q;

	always_ff @(posedge clk) begin
		if (cmd.first_acc) begin
			dec_q      <= in_decode;
			pal4_q     <= in_decode && (fmt == FMT_4BIT);
			pal8_q     <= in_decode && (fmt == FMT_8BIT);
			u_lo_q     <= tex_u[1:0];
			pal_word_q <= palette_word;
		end
	end

	assign sts.paletted = pal4_q | pal8_q;

	// palette address from the fetched index word
	logic [15:0]        rdata_q;
	logic               byte_sel;
	logic [7:0]         idx_byte, pal_idx;
	logic [COORD_W-1:0] pal_col, pal_row, pal_col_c, pal_row_c;
	logic [AW-1:0]      pal_addr;

	assign byte_sel = pal4_q ? u_lo_q[1] : u_lo_q[0];
	assign idx_byte = byte_sel ? rdata_q[15:8] : rdata_q[7:0];
	assign pal_idx  = pal4_q ? {4'b0, (u_lo_q[0] ? idx_byte[7:4] : idx_byte[3:0])} : idx_byte;
	assign pal_col  = COORD_W'({pal_word_q[5:0], 4'b0}) + COORD_W'(pal_idx);
	assign pal_row  = COORD_W'(pal_word_q[15:6]);
	assign pal_col_c = clamp_coord(pal_col, W_LIM);
	assign pal_row_c = clamp_coord(pal_row, H_LIM);
	assign pal_addr  = {pal_row_c[RW-1:0], pal_col_c[CW-1:0]};

	// clearing sweep address
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	assign sts.clear_last = (clr_addr_q == LAST_ADDR);

	// store port select
	logic [AW-1:0] mem_addr;
	logic [15:0]   mem_wdata;
	logic          mem_we, mem_re;

	always_comb begin
		if (cmd.clear_wr) begin
			mem_addr = clr_addr_q;
		end else if (cmd.second_rd) begin
			mem_addr = pal_addr;
		end else begin
			mem_addr = first_addr;
		end
	end

	assign mem_wdata = cmd.clear_wr ? 16'h0 : write_data;
	assign mem_we    = cmd.clear_wr | (cmd.first_acc & in_write);
	assign mem_re    = (cmd.first_acc & sts.in_result) | cmd.second_rd;

	// single-port video store, registered read
	logic [15:0] vram_q [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vram_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= vram_q[mem_addr];
		end
	end

	// output register: plain word or expanded rgb555
	logic [M_TDATA_W-1:0] out_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (dec_q) begin
				out_q <= {ALPHA_OPAQUE, rdata_q[14:10], 3'b0, rdata_q[9:5], 3'b0,
					rdata_q[4:0], 3'b0, 16'h0};
			end else begin
				out_q <= {32'h0, rdata_q};
			end
		end
	end

	assign m_tdata = out_q;

endmodule

// File: design/ptf_controller.sv
// ----------------------------------------------------------------------------
// ptf_controller
// sequencer for store clearing, access ordering and output handshake
// ----------------------------------------------------------------------------
`include "paletted_texel_fetch_defines.svh"

module ptf_controller import ptf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  ptf_sts_t sts,
	output ptf_cmd_t cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_WAIT1 = 2'd2;
	localparam logic [1:0] S_WAIT2 = 2'd3;

	logic [1:0] state_q, state_nxt;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.first_acc = 1'b1;
					if (sts.in_result) begin
						state_nxt = S_WAIT1;
					end
				end
			end
			S_WAIT1: begin
				if (sts.paletted) begin
					cmd.second_rd = 1'b1;
					state_nxt     = S_WAIT2;
				end else if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_WAIT2: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_CLEAR;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// checks
	`PTF_ASSERT_NOW(a_load_slot_free, clk, arst_n, cmd.out_load, out_free, "output overwritten")
	`PTF_ASSERT_NOW(a_second_rd_src, clk, arst_n, cmd.second_rd,
		(state_q == S_WAIT1) && sts.paletted, "palette read out of sequence")
	`PTF_ASSERT_NEXT(a_result_wait, clk, arst_n, s_tvalid && s_tready && sts.in_result,
		state_q == S_WAIT1, "result beat not followed by store wait")
	`PTF_ASSERT_NEXT(a_clear_no_out, clk, arst_n, state_q == S_CLEAR,
		!m_tvalid_q, "output during clearing")

endmodule

// File: design/paletted_texel_fetch.sv
// ----------------------------------------------------------------------------
// paletted_texel_fetch
// video word store with word read/write and paletted texel decode
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one command per beat; s_tuser selects write, read or decode.
//   a write produces no output beat; a read returns the stored word and a
//   decode returns 8-bit red, green, blue and alpha on m_*.
//   a read or direct 16-bit decode passes the registered store read and the
//   output register; a 4-bit or 8-bit paletted decode adds a palette read.
//   s_tready stays low from a read or decode until its result is loaded; a
//   write is done on accept. the single store port carries one access per
//   cycle and the palette read waits for the index word.
//   after reset the store is swept to zero, one word per cycle, over all
//   STORE_HEIGHT * 2**clog2(STORE_WIDTH) words (524288 at the defaults);
//   s_tready stays low until the sweep ends.
//   when the receiver stalls, one result waits in the output register; writes
//   still pass; one more read or decode is accepted and waits for the output.
//   column and row are clamped to the store edges for every access.
// ----------------------------------------------------------------------------
module paletted_texel_fetch import ptf_pkg::*; #(
	parameter int STORE_WIDTH  = 1024,
	parameter int STORE_HEIGHT = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// vram_x, vram_y, write_data, page_word, palette_word, tex_u, tex_v, zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	// command
	input  logic [CMD_W-1:0]     s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// read_word, red, green, blue, alpha
	output logic [M_TDATA_W-1:0] m_tdata
);

	ptf_cmd_t cmd;
	ptf_sts_t sts;

	ptf_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptf_datapath #(
		.STORE_WIDTH  (STORE_WIDTH),
		.STORE_HEIGHT (STORE_HEIGHT)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata)
	);

endmodule

// File: dv/paletted_texel_fetch_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paletted_texel_fetch_tb
// self-checking bench for the word store and paletted texel decode
// ----------------------------------------------------------------------------
// a shadow copy of the video store is updated on every accepted command beat
// and yields the read word or decoded color that each output beat must carry.
// stimulus opens with edge coordinates, every command and every format, then
// runs random traffic built mostly from index-word / palette-entry / decode
// triples so that paletted fetches land on written data. both sides idle in
// short random bursts; the receiver also holds off once for a long stretch
// and the sender once waits for the output side to drain.
// ----------------------------------------------------------------------------
module paletted_texel_fetch_tb;
	import ptf_pkg::*;

	localparam int STORE_W     = 1024;
	localparam int STORE_H     = 512;
	localparam int ITEM_COUNT  = 1050;
	localparam int HOLD_CYCLES = 200;
	localparam int TAIL_CYCLES = 8;
	localparam int HOLD_AT     = 300;
	localparam int DRAIN_AT    = 620;

	// command code the block ignores
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// one command beat as queued for the sender
	typedef struct {
		logic [1:0]  cmd;
		logic [9:0]  x;
		logic [8:0]  y;
		logic [15:0] data;
		logic [15:0] page;
		logic [15:0] pal;
		logic [7:0]  u;
		logic [7:0]  v;
		logic        hold;  // start the long receiver hold-off with this beat
		logic        drain; // wait for every result before sending this beat
	} fetch_cmd_t;

	// output beat, lowest field in the lowest bits
	typedef struct packed {
		logic [7:0]  alpha;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [15:0] read_word;
	} texel_beat_t;

	typedef struct {
		logic [9:0] x;
		logic [8:0] y;
	} loc_t;

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [CMD_W-1:0]     s_tuser  = CMD_WRITE;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	fetch_cmd_t  cmd_backlog[$];
	texel_beat_t words_due[$];
	loc_t        recent_writes[$];
	logic [15:0] vram_shadow [0:STORE_W*STORE_H-1];

	logic settled       = 1'b1;
	logic backlog_empty = 1'b0;
	logic calm          = 1'b0;
	logic hold_req      = 1'b0;
	int   hold_left     = 0;
	int   gap_left      = 0;
	int   stall_left    = 0;
	int   launched      = 0;
	int   mismatches    = 0;

	paletted_texel_fetch #(
		.STORE_WIDTH (STORE_W),
		.STORE_HEIGHT(STORE_H)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// store addressing with edge clamp
	function automatic loc_t clamp_loc(int col, int row);
		loc_t at;
		at.x = (col >= STORE_W) ? 10'(STORE_W - 1) : 10'(col);
		at.y = (row >= STORE_H) ? 9'(STORE_H - 1) : 9'(row);
		return at;
	endfunction

	function automatic int shadow_index(loc_t at);
		return int'(at.y) * STORE_W + int'(at.x);
	endfunction

	// word holding the index (paletted) or the color (direct)
	function automatic loc_t texel_word_loc(logic [15:0] page, logic [7:0] u, logic [7:0] v);
		int col;
		int row;
		col = int'(page[3:0]) * 64;
		row = int'(v) + (page[4] ? 256 : 0) + (page[11] ? 512 : 0);
		case (page[8:7])
			FMT_4BIT: col += int'(u[7:2]);
			FMT_8BIT: col += int'(u[7:1]);
			default:  col += int'(u);
		endcase
		return clamp_loc(col, row);
	endfunction

	// nibble or byte of the index word that this texel uses
	function automatic logic [7:0] palette_index(logic [1:0] fmt, logic [7:0] u,
			logic [15:0] word);
		logic [7:0] sel;
		if (fmt == FMT_4BIT) begin
			sel = u[1] ? word[15:8] : word[7:0];
			return u[0] ? {4'h0, sel[7:4]} : {4'h0, sel[3:0]};
		end
		return u[0] ? word[15:8] : word[7:0];
	endfunction

	function automatic loc_t palette_loc(logic [15:0] pal, logic [7:0] idx);
		return clamp_loc(int'(pal[5:0]) * 16 + int'(idx), int'(pal[15:6]));
	endfunction

	// rgb555 word that a decode fetches from the shadow store
	function automatic logic [15:0] texel_color(logic [15:0] page, logic [15:0] pal,
			logic [7:0] u, logic [7:0] v);
		logic [15:0] word;
		word = vram_shadow[shadow_index(texel_word_loc(page, u, v))];
		if (page[8:7] == FMT_4BIT || page[8:7] == FMT_8BIT)
			word = vram_shadow[shadow_index(palette_loc(pal, palette_index(page[8:7], u, word)))];
		return word;
	endfunction

	// update the shadow store and queue the result of one accepted beat
	task automatic apply_command(logic [1:0] cmd, logic [S_TDATA_W-1:0] beat);
		loc_t        at;
		logic [15:0] word;
		texel_beat_t res;
		at.x = beat[9:0];
		at.y = beat[18:10];
		res  = '0;
		case (cmd)
			CMD_WRITE: vram_shadow[shadow_index(at)] = beat[34:19];
			CMD_READ: begin
				res.read_word = vram_shadow[shadow_index(at)];
				words_due.push_back(res);
			end
			CMD_DECODE: begin
				word = texel_color(beat[50:35], beat[66:51], beat[74:67], beat[82:75]);
				res.red   = {word[4:0], 3'b000};
				res.green = {word[9:5], 3'b000};
				res.blue  = {word[14:10], 3'b000};
				res.alpha = ALPHA_OPAQUE;
				words_due.push_back(res);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string field, logic [M_TDATA_W-1:0] got,
			logic [M_TDATA_W-1:0] want);
		if (mismatches < 40)
			$display("%0t: %s got %0h, want %0h", $time, field, got, want);
		mismatches++;
	endtask

	// stimulus helpers
	function automatic fetch_cmd_t rand_cmd(logic [1:0] cmd);
		fetch_cmd_t c;
		c.cmd   = cmd;
		c.x     = 10'($urandom);
		c.y     = 9'($urandom);
		c.data  = 16'($urandom);
		c.page  = 16'($urandom);
		c.pal   = 16'($urandom);
		c.u     = 8'($urandom);
		c.v     = 8'($urandom);
		c.hold  = 1'b0;
		c.drain = 1'b0;
		return c;
	endfunction

	task automatic queue_access(logic [1:0] cmd, loc_t at, logic [15:0] data);
		fetch_cmd_t c;
		c      = rand_cmd(cmd);
		c.x    = at.x;
		c.y    = at.y;
		c.data = data;
		cmd_backlog.push_back(c);
		if (cmd == CMD_WRITE) begin
			recent_writes.push_back(at);
			if (recent_writes.size() > 64)
				void'(recent_writes.pop_front());
		end
	endtask

	// index word, palette entry if paletted, then the decode reading them back
	task automatic queue_texel(logic [15:0] page, logic [15:0] pal, logic [7:0] u,
			logic [7:0] v);
		fetch_cmd_t  c;
		logic [15:0] word;
		word = 16'($urandom);
		queue_access(CMD_WRITE, texel_word_loc(page, u, v), word);
		if (page[8:7] == FMT_4BIT || page[8:7] == FMT_8BIT)
			queue_access(CMD_WRITE, palette_loc(pal, palette_index(page[8:7], u, word)),
				16'($urandom));
		c      = rand_cmd(CMD_DECODE);
		c.page = page;
		c.pal  = pal;
		c.u    = u;
		c.v    = v;
		cmd_backlog.push_back(c);
	endtask

	// sender: one beat in flight, random gaps between beats
	always @(posedge clk or negedge arst_n) begin
		fetch_cmd_t nxt;
		logic       offer;
		logic       hold_pulse;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= CMD_WRITE;
			hold_req <= 1'b0;
			calm     <= 1'b0;
			gap_left = 0;
		end else begin
			offer      = 1'b0;
			hold_pulse = 1'b0;
			if (s_tvalid && !s_tready) begin
				offer = 1'b1;
			end else if (gap_left != 0) begin
				gap_left--;
			end else if (cmd_backlog.size() != 0 &&
					!(cmd_backlog[0].drain && (s_tvalid || !settled))) begin
				if (!calm && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 4);
				end else begin
					nxt = cmd_backlog.pop_front();
					s_tdata <= {5'b0, nxt.v, nxt.u, nxt.pal, nxt.page, nxt.data, nxt.y, nxt.x};
					s_tuser <= nxt.cmd;
					offer      = 1'b1;
					hold_pulse = nxt.hold;
					launched++;
				end
			end
			s_tvalid      <= offer;
			hold_req      <= hold_pulse;
			backlog_empty <= (cmd_backlog.size() == 0);
			calm          <= (cmd_backlog.size() < 150) || ((launched / 90) % 4 == 3);
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: check output beats, track accepted command beats, stall at random
	always @(posedge clk or negedge arst_n) begin
		texel_beat_t got;
		texel_beat_t want;
		logic        rdy;
		if (!arst_n) begin
			m_tready <= 1'b0;
			settled  <= 1'b1;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (words_due.size() == 0) begin
					report_mismatch("beat with nothing due", got, '0);
				end else begin
					want = words_due.pop_front();
					if (got.read_word !== want.read_word)
						report_mismatch("read_word", M_TDATA_W'(got.read_word),
							M_TDATA_W'(want.read_word));
					if (got.red !== want.red)
						report_mismatch("red", M_TDATA_W'(got.red), M_TDATA_W'(want.red));
					if (got.green !== want.green)
						report_mismatch("green", M_TDATA_W'(got.green), M_TDATA_W'(want.green));
					if (got.blue !== want.blue)
						report_mismatch("blue", M_TDATA_W'(got.blue), M_TDATA_W'(want.blue));
					if (got.alpha !== want.alpha)
						report_mismatch("alpha", M_TDATA_W'(got.alpha), M_TDATA_W'(want.alpha));
				end
			end
			if (s_tvalid && s_tready)
				apply_command(s_tuser, s_tdata);
			settled <= (words_due.size() == 0);

			rdy = 1'b1;
			if (stall_left != 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 4);
				rdy = 1'b0;
			end
			m_tready <= rdy && (hold_left == 0);
		end
	end

	// stimulus, reset and end of run
	initial begin
		fetch_cmd_t c;
		loc_t       at;
		int         pick;

		// store reads as zero after reset
		foreach (vram_shadow[i])
			vram_shadow[i] = 16'h0;

		// store corners, reset contents and the ignored command
		queue_access(CMD_WRITE, clamp_loc(1023, 511), 16'hffff);
		queue_access(CMD_READ, clamp_loc(1023, 511), 16'h0);
		queue_access(CMD_READ, clamp_loc(512, 256), 16'h0);
		queue_access(CMD_WRITE, clamp_loc(0, 0), 16'h7fe0);
		queue_access(CMD_READ, clamp_loc(0, 0), 16'h0);
		queue_access(CMD_UNUSED, clamp_loc(0, 0), 16'h1234);
		queue_access(CMD_READ, clamp_loc(0, 0), 16'h0);

		// direct format at the origin, reserved format clamped to the far corner
		c = rand_cmd(CMD_DECODE);
		c.page = 16'h0100;
		c.u    = 8'd0;
		c.v    = 8'd0;
		cmd_backlog.push_back(c);
		c = rand_cmd(CMD_DECODE);
		c.page = 16'h098f;
		c.u    = 8'd255;
		c.v    = 8'd255;
		cmd_backlog.push_back(c);

		// paletted fetches: nibble and byte lanes, high page rows, palette past the edge
		queue_texel(16'h0000, 16'h0000, 8'd3, 8'd0);
		queue_texel(16'h0000, 16'h0040, 8'd0, 8'd1);
		queue_texel(16'h0090, 16'hffff, 8'd255, 8'd255);
		queue_texel(16'h0880, 16'h003f, 8'd0, 8'd0);
		queue_texel(16'h0810, 16'hffc0, 8'd254, 8'd128);

		// random traffic, mostly fetch triples
		while (cmd_backlog.size() < ITEM_COUNT) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				queue_texel(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
				if ($urandom_range(0, 3) == 0)
					queue_access(CMD_READ, recent_writes[$], 16'h0);
			end else if (pick < 70) begin
				cmd_backlog.push_back(rand_cmd(CMD_WRITE));
			end else if (pick < 85) begin
				c = rand_cmd(CMD_READ);
				if ($urandom_range(0, 1) == 0) begin
					at  = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
					c.x = at.x;
					c.y = at.y;
				end
				cmd_backlog.push_back(c);
			end else if (pick < 95) begin
				cmd_backlog.push_back(rand_cmd(CMD_DECODE));
			end else begin
				cmd_backlog.push_back(rand_cmd(CMD_UNUSED));
			end
		end
		cmd_backlog[HOLD_AT].hold   = 1'b1;
		cmd_backlog[DRAIN_AT].drain = 1'b1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (!(backlog_empty && !s_tvalid && settled));
		repeat (TAIL_CYCLES) @(posedge clk);
		if (words_due.size() != 0)
			report_mismatch("results never returned", M_TDATA_W'(words_due.size()), '0);

		if (mismatches == 0)
			$display("paletted_texel_fetch: match");
		else
			$display("paletted_texel_fetch: mismatch");
		$finish;
	end

	// timeout, covers the store clearing sweep after reset
	initial begin
		#30_000_000;
		$display("paletted_texel_fetch: mismatch");
		$finish;
	end

endmodule
